@@ sv/assert_macros.svh @@
// assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, muted while reset is high
`define KEMT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kemt check failed");

// same check with no reset gating
`define KEMT_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("kemt check failed");

`endif

@@ sv/kemt_pkg.sv @@
`default_nettype none
package kemt_pkg;

   localparam int ENTRIES = 6;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SEEN_W  = (CNT_W > 3) ? CNT_W : 3;

   localparam logic [31:0] NEVER_EXPIRES = 32'hFFFF_FFFF;
   // floor(x / 1000) for any 32-bit x is (x * DIV_MAGIC) >> DIV_SHIFT
   localparam logic [31:0] DIV_MAGIC = 32'h1062_4DD3;
   localparam int          DIV_SHIFT = 38;

   typedef enum logic [2:0] {
      FN_PUT       = 3'd0,
      FN_TICK      = 3'd1,
      FN_CLR_KEY   = 3'd2,
      FN_CLR_TOPIC = 3'd3,
      FN_READ_NTH  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0]  topic;
      logic [7:0]  msg_id;
      logic [31:0] expiry;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } wr_type;

endpackage
`default_nettype wire

@@ sv/kemt_store.sv @@
`default_nettype none
module kemt_store (
   input  wire logic                       clock,
   input  wire kemt_pkg::wr_type           wr,
   input  wire logic [kemt_pkg::IDX_W-1:0] rd_addr,
   output kemt_pkg::entry_type             rd_data
);

   kemt_pkg::entry_type mem_ff [kemt_pkg::ENTRIES];
   kemt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/kemt_limit.sv @@
`default_nettype none
module kemt_limit (
   input  wire logic        clock,
   input  wire logic [31:0] now_us,
   output logic      [31:0] limit
);

   logic [63:0] prod_in;
   logic [63:0] prod_ff;

   // us to ms by reciprocal multiply
   assign prod_in = {32'd0, now_us} * {32'd0, kemt_pkg::DIV_MAGIC};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign limit = 32'(prod_ff >> kemt_pkg::DIV_SHIFT);

endmodule
`default_nettype wire

@@ sv/keyed_expiring_message_table.sv @@
// steps: a scan of the entry memory at one read per cycle, then a writeback in the done
// state, then the idle state, where the next beat is taken; a new operation is accepted
// only in that idle state, so operations do not overlap
// busy is high from the accepting edge until the result beat; the receiver cannot stall
// reset clears valid marks, live count and control; entry contents are left as they are
`default_nettype none
module keyed_expiring_message_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_topic,
   input  wire logic [7:0]  req_msg_id,
   input  wire logic [31:0] req_expires_in,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [31:0] req_now_us,
   input  wire logic [31:0] req_payload,
   input  wire logic [2:0]  req_position,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic             rsp_found,
   output logic [31:0]      rsp_out_payload,
   output logic [7:0]       rsp_out_topic,
   output logic [7:0]       rsp_out_msg_id,
   output logic [2:0]       rsp_live_count
);

   localparam int IDX_W  = kemt_pkg::IDX_W;
   localparam int CNT_W  = kemt_pkg::CNT_W;
   localparam int SEEN_W = kemt_pkg::SEEN_W;

   kemt_pkg::state_type state_ff, state_in;

   logic                     accept;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     eval_vld_ff;
   logic [IDX_W-1:0]         eval_idx_ff;
   logic [kemt_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   kemt_pkg::func_type       func_ff;
   logic [7:0]               topic_ff, msg_id_ff;
   logic [31:0]              span_ff, now_ms_ff, now_us_ff, payload_ff;
   logic [2:0]               position_ff;

   logic                     match_ff, match_in;
   logic [IDX_W-1:0]         match_idx_ff, match_idx_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [31:0]              best_exp_ff, best_exp_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [SEEN_W-1:0]        seen_ff, seen_in;
   logic                     fnd_ff, fnd_in;
   logic [31:0]              fpay_ff, fpay_in;
   logic [7:0]               ftop_ff, ftop_in;
   logic [7:0]               fid_ff, fid_in;

   logic                     rsp_valid_ff;
   logic                     rsp_accepted_ff, rsp_found_ff;
   logic [31:0]              rsp_payload_ff;
   logic [7:0]               rsp_topic_ff, rsp_msg_id_ff;
   logic [2:0]               rsp_count_ff;

   kemt_pkg::entry_type      rd_data;
   kemt_pkg::wr_type         wr;
   logic [IDX_W-1:0]         rd_addr;
   logic [31:0]              limit;

   logic                     ent_valid, key_hit, topic_hit, free_now;
   logic                     put_op, put_ok;
   logic [IDX_W-1:0]         slot;
   logic [31:0]              new_expiry;

   kemt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kemt_limit u_limit (
      .clock  (clock),
      .now_us (now_us_ff),
      .limit  (limit)
   );

   assign accept = start && (state_ff == kemt_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kemt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = kemt_pkg::ST_SCAN;
            end
         end
         kemt_pkg::ST_SCAN: begin
            if (cnt_ff == CNT_W'(kemt_pkg::ENTRIES)) begin
               state_in = kemt_pkg::ST_DONE;
            end
         end
         kemt_pkg::ST_DONE: begin
            state_in = kemt_pkg::ST_IDLE;
         end
         default: begin
            state_in = kemt_pkg::ST_IDLE;
         end
      endcase
   end

   // per-entry evaluation and put slot choice
   always_comb begin
      ent_valid = eval_vld_ff && valid_ff[eval_idx_ff];
      topic_hit = ent_valid && (rd_data.topic == topic_ff);
      key_hit   = topic_hit && (rd_data.msg_id == msg_id_ff);
      put_op    = (func_ff == kemt_pkg::FN_PUT);

      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_exp_in  = best_exp_ff;
      best_idx_in  = best_idx_ff;
      seen_in      = seen_ff;
      fnd_in       = fnd_ff;
      fpay_in      = fpay_ff;
      ftop_in      = ftop_ff;
      fid_in       = fid_ff;
      free_now     = 1'b0;

      if (state_ff == kemt_pkg::ST_SCAN) begin
         case (func_ff)
            kemt_pkg::FN_PUT: begin
               if (key_hit && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = eval_idx_ff;
               end
               if (eval_vld_ff && !valid_ff[eval_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = eval_idx_ff;
               end
               if (ent_valid && (rd_data.expiry < best_exp_ff)) begin
                  best_exp_in = rd_data.expiry;
                  best_idx_in = eval_idx_ff;
               end
            end
            kemt_pkg::FN_TICK: begin
               free_now = ent_valid && (rd_data.expiry < limit);
            end
            kemt_pkg::FN_CLR_KEY: begin
               if (key_hit && !match_ff) begin
                  free_now = 1'b1;
                  match_in = 1'b1;
               end
            end
            kemt_pkg::FN_CLR_TOPIC: begin
               free_now = topic_hit;
            end
            kemt_pkg::FN_READ_NTH: begin
               if (ent_valid && !fnd_ff) begin
                  if (seen_ff == SEEN_W'(position_ff)) begin
                     fnd_in  = 1'b1;
                     fpay_in = rd_data.payload;
                     ftop_in = rd_data.topic;
                     fid_in  = rd_data.msg_id;
                  end else begin
                     seen_in = seen_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (match_ff) begin
         slot = match_idx_ff;
      end else if (free_ff) begin
         slot = free_idx_ff;
      end else begin
         slot = best_idx_ff;
      end
      put_ok     = put_op && (match_ff || free_ff || (best_exp_ff != kemt_pkg::NEVER_EXPIRES));
      new_expiry = (span_ff == 32'd0) ? kemt_pkg::NEVER_EXPIRES : (now_ms_ff + span_ff);

      valid_in = valid_ff;
      count_in = count_ff;
      if (free_now) begin
         valid_in[eval_idx_ff] = 1'b0;
         count_in              = count_ff - 1'b1;
      end
      if ((state_ff == kemt_pkg::ST_DONE) && put_ok) begin
         valid_in[slot] = 1'b1;
         if (!match_ff && free_ff) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // outputs and memory ports
   always_comb begin
      busy         = (state_ff != kemt_pkg::ST_IDLE);
      rd_addr      = cnt_ff[IDX_W-1:0];
      cnt_in       = (state_ff == kemt_pkg::ST_SCAN) ? (cnt_ff + 1'b1) : '0;
      wr.en        = (state_ff == kemt_pkg::ST_DONE) && put_ok;
      wr.addr      = slot;
      wr.data      = '{topic: topic_ff, msg_id: msg_id_ff, expiry: new_expiry,
                       payload: payload_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kemt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         eval_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         eval_vld_ff  <= (state_ff == kemt_pkg::ST_SCAN) &&
                         (cnt_ff < CNT_W'(kemt_pkg::ENTRIES));
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= (state_ff == kemt_pkg::ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= cnt_ff[IDX_W-1:0];
      if (accept) begin
         func_ff      <= kemt_pkg::func_type'(req_func);
         topic_ff     <= req_topic;
         msg_id_ff    <= req_msg_id;
         span_ff      <= req_expires_in;
         now_ms_ff    <= req_now_ms;
         now_us_ff    <= req_now_us;
         payload_ff   <= req_payload;
         position_ff  <= req_position;
         match_ff     <= 1'b0;
         match_idx_ff <= '0;
         free_ff      <= 1'b0;
         free_idx_ff  <= '0;
         best_exp_ff  <= kemt_pkg::NEVER_EXPIRES;
         best_idx_ff  <= '0;
         seen_ff      <= '0;
         fnd_ff       <= 1'b0;
         fpay_ff      <= '0;
         ftop_ff      <= '0;
         fid_ff       <= '0;
      end else begin
         match_ff     <= match_in;
         match_idx_ff <= match_idx_in;
         free_ff      <= free_in;
         free_idx_ff  <= free_idx_in;
         best_exp_ff  <= best_exp_in;
         best_idx_ff  <= best_idx_in;
         seen_ff      <= seen_in;
         fnd_ff       <= fnd_in;
         fpay_ff      <= fpay_in;
         ftop_ff      <= ftop_in;
         fid_ff       <= fid_in;
      end
      if (state_ff == kemt_pkg::ST_DONE) begin
         rsp_accepted_ff <= put_ok;
         rsp_found_ff    <= fnd_ff;
         rsp_payload_ff  <= fpay_ff;
         rsp_topic_ff    <= ftop_ff;
         rsp_msg_id_ff   <= fid_ff;
         rsp_count_ff    <= 3'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_out_topic   = rsp_topic_ff;
   assign rsp_out_msg_id  = rsp_msg_id_ff;
   assign rsp_live_count  = rsp_count_ff;

endmodule
`default_nettype wire

@@ sv/kemt_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module kemt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_accepted,
   input wire logic        rsp_found,
   input wire logic [31:0] rsp_out_payload,
   input wire logic [7:0]  rsp_out_topic,
   input wire logic [7:0]  rsp_out_msg_id
);

   // an accepted beat keeps the block busy
   `KEMT_ASSERT(a_busy_after_start, clock, reset, (start && !busy) |=> busy)
   // result strobe lasts one cycle
   `KEMT_ASSERT(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid)
   // leaving busy delivers a result, unless reset forced the fall
   `KEMT_ASSERT(a_fall_gives_rsp, clock, reset, $fell(busy) |-> (rsp_valid || $past(reset)))
   // put and read nth never report at once
   `KEMT_ASSERT(a_acc_fnd_excl, clock, reset, rsp_valid |-> !(rsp_accepted && rsp_found))
   // missing entry reads as zero
   `KEMT_ASSERT(a_miss_zero, clock, reset, (rsp_valid && !rsp_found) |-> ((rsp_out_payload == 32'd0) && (rsp_out_topic == 8'd0) && (rsp_out_msg_id == 8'd0)))

endmodule

bind keyed_expiring_message_table kemt_checker u_kemt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_accepted    (rsp_accepted),
   .rsp_found       (rsp_found),
   .rsp_out_payload (rsp_out_payload),
   .rsp_out_topic   (rsp_out_topic),
   .rsp_out_msg_id  (rsp_out_msg_id)
);
`default_nettype wire

@@ test/tb_keyed_expiring_message_table.sv @@
`default_nettype none
module tb_keyed_expiring_message_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0]  FN_SPARE_LO  = 3'd5;
   localparam logic [2:0]  FN_SPARE_HI  = 3'd7;
   localparam logic [31:0] US_PER_MS    = 32'd1000;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          MAX_GAP      = 40;
   localparam int          DRAIN_CYCLES = kemt_pkg::ENTRIES + 4;
   localparam int          PHASE_OPS    = 463;

   typedef struct {
      logic [2:0]  func;
      logic [7:0]  topic;
      logic [7:0]  msg_id;
      logic [31:0] expires_in;
      logic [31:0] now_ms;
      logic [31:0] now_us;
      logic [31:0] payload;
      logic [2:0]  position;
   } op_req_type;

   typedef struct {
      logic        accepted;
      logic        found;
      logic [31:0] payload;
      logic [7:0]  topic;
      logic [7:0]  msg_id;
      logic [2:0]  live_count;
   } op_reply_type;

   class table_scoreboard;
      bit                  in_use[kemt_pkg::ENTRIES];
      kemt_pkg::entry_type slots[kemt_pkg::ENTRIES];
      int unsigned         live;
      op_reply_type        awaited_replies[$];
      int unsigned         errors;
      int unsigned         ops;
      int unsigned         checked;
      int unsigned         stored;
      int unsigned         refused;
      int unsigned         reads_hit;

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      function op_reply_type apply_table_op(op_req_type r);
         op_reply_type res;
         logic [31:0]  expiry;
         logic [31:0]  best;
         logic [31:0]  cutoff;
         int           pick;
         int           seen;
         res = '{default: '0};
         expiry = (r.expires_in != 32'd0) ? r.now_ms + r.expires_in
                                          : kemt_pkg::NEVER_EXPIRES;
         cutoff = r.now_us / US_PER_MS;
         pick = -1;
         seen = 0;
         case (r.func)
            kemt_pkg::FN_PUT: begin
               for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                  if (pick < 0 && in_use[s] && slots[s].topic == r.topic &&
                      slots[s].msg_id == r.msg_id)
                     pick = s;
               if (pick < 0)
                  for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                     if (pick < 0 && !in_use[s]) begin
                        pick = s;
                        live++;
                     end
               if (pick < 0) begin
                  best = kemt_pkg::NEVER_EXPIRES;
                  for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                     if (in_use[s] && slots[s].expiry < best) begin
                        best = slots[s].expiry;
                        pick = s;
                     end
               end
               if (pick >= 0) begin
                  in_use[pick] = 1'b1;
                  slots[pick] = '{topic: r.topic, msg_id: r.msg_id, expiry: expiry,
                                  payload: r.payload};
                  res.accepted = 1'b1;
               end
            end
            kemt_pkg::FN_TICK: begin
               for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                  if (in_use[s] && slots[s].expiry < cutoff) begin
                     in_use[s] = 1'b0;
                     live--;
                  end
            end
            kemt_pkg::FN_CLR_KEY: begin
               for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                  if (pick < 0 && in_use[s] && slots[s].topic == r.topic &&
                      slots[s].msg_id == r.msg_id) begin
                     pick = s;
                     in_use[s] = 1'b0;
                     live--;
                  end
            end
            kemt_pkg::FN_CLR_TOPIC: begin
               for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                  if (in_use[s] && slots[s].topic == r.topic) begin
                     in_use[s] = 1'b0;
                     live--;
                  end
            end
            kemt_pkg::FN_READ_NTH: begin
               for (int s = 0; s < kemt_pkg::ENTRIES; s++)
                  if (in_use[s] && !res.found) begin
                     if (seen == r.position) begin
                        res.found = 1'b1;
                        res.payload = slots[s].payload;
                        res.topic = slots[s].topic;
                        res.msg_id = slots[s].msg_id;
                     end
                     seen++;
                  end
            end
            default: ;
         endcase
         res.live_count = live[2:0];
         return res;
      endfunction

      function void note_request(op_req_type r);
         op_reply_type res;
         res = apply_table_op(r);
         ops++;
         if (r.func == kemt_pkg::FN_PUT) begin
            if (res.accepted)
               stored++;
            else
               refused++;
         end
         if (res.found)
            reads_hit++;
         awaited_replies.push_back(res);
      endfunction

      task check_result(op_reply_type got);
         op_reply_type want;
         checked++;
         if (awaited_replies.size() == 0) begin
            report("reply beat with no operation outstanding");
            return;
         end
         want = awaited_replies.pop_front();
         if (got.accepted !== want.accepted)
            report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
         if (got.found !== want.found)
            report($sformatf("found got %0b want %0b", got.found, want.found));
         if (got.payload !== want.payload)
            report($sformatf("out_payload got %h want %h", got.payload, want.payload));
         if (got.topic !== want.topic)
            report($sformatf("out_topic got %h want %h", got.topic, want.topic));
         if (got.msg_id !== want.msg_id)
            report($sformatf("out_msg_id got %h want %h", got.msg_id, want.msg_id));
         if (got.live_count !== want.live_count)
            report($sformatf("live_count got %0d want %0d", got.live_count, want.live_count));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_topic = '0;
   logic [7:0]  req_msg_id = '0;
   logic [31:0] req_expires_in = '0;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_now_us = '0;
   logic [31:0] req_payload = '0;
   logic [2:0]  req_position = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_accepted;
   logic        rsp_found;
   logic [31:0] rsp_out_payload;
   logic [7:0]  rsp_out_topic;
   logic [7:0]  rsp_out_msg_id;
   logic [2:0]  rsp_live_count;

   table_scoreboard sb;
   int          idle_pct;
   int          stall_cycles = 0;
   logic [31:0] ms_now;

   keyed_expiring_message_table u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_topic       (req_topic),
      .req_msg_id      (req_msg_id),
      .req_expires_in  (req_expires_in),
      .req_now_ms      (req_now_ms),
      .req_now_us      (req_now_us),
      .req_payload     (req_payload),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_accepted    (rsp_accepted),
      .rsp_found       (rsp_found),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_topic   (rsp_out_topic),
      .rsp_out_msg_id  (rsp_out_msg_id),
      .rsp_live_count  (rsp_live_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      op_req_type   seen_req;
      op_reply_type seen_rsp;
      if (!reset) begin
         if (rsp_valid) begin
            seen_rsp = '{accepted: rsp_accepted, found: rsp_found, payload: rsp_out_payload,
                         topic: rsp_out_topic, msg_id: rsp_out_msg_id,
                         live_count: rsp_live_count};
            sb.check_result(seen_rsp);
         end
         if (start && !busy) begin
            seen_req = '{func: req_func, topic: req_topic, msg_id: req_msg_id,
                         expires_in: req_expires_in, now_ms: req_now_ms,
                         now_us: req_now_us, payload: req_payload, position: req_position};
            sb.note_request(seen_req);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic op_req_type mk_op(logic [2:0] func, logic [7:0] topic,
                                        logic [7:0] msg_id, logic [31:0] span,
                                        logic [31:0] now_ms, logic [31:0] now_us,
                                        logic [31:0] payload, logic [2:0] position);
      op_req_type r;
      r = '{func: func, topic: topic, msg_id: msg_id, expires_in: span, now_ms: now_ms,
            now_us: now_us, payload: payload, position: position};
      return r;
   endfunction

   function automatic logic [7:0] pick_key_byte();
      return ($urandom_range(99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
   endfunction

   function automatic op_req_type random_op();
      op_req_type r;
      int         roll;
      int         sroll;
      roll = $urandom_range(99);
      sroll = $urandom_range(99);
      r.func = (roll < 40) ? kemt_pkg::FN_PUT :
               (roll < 55) ? kemt_pkg::FN_TICK :
               (roll < 67) ? kemt_pkg::FN_CLR_KEY :
               (roll < 75) ? kemt_pkg::FN_CLR_TOPIC :
               (roll < 95) ? kemt_pkg::FN_READ_NTH :
                             3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      r.topic = pick_key_byte();
      r.msg_id = pick_key_byte();
      r.expires_in = (sroll < 10) ? 32'd0 :
                     (sroll < 80) ? 32'($urandom_range(1, 3000)) : 32'($urandom);
      r.now_ms = ($urandom_range(99) < 90) ? ms_now : 32'($urandom);
      r.now_us = ($urandom_range(99) < 85) ? ms_now * US_PER_MS + $urandom_range(0, 999)
                                          : 32'($urandom);
      r.payload = $urandom;
      r.position = 3'($urandom_range(0, 7));
      return r;
   endfunction

   task automatic sender_gap();
      int n;
      n = 0;
      while (n < MAX_GAP && $urandom_range(99) < idle_pct)
         n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue(op_req_type r);
      req_func <= r.func;
      req_topic <= r.topic;
      req_msg_id <= r.msg_id;
      req_expires_in <= r.expires_in;
      req_now_ms <= r.now_ms;
      req_now_us <= r.now_us;
      req_payload <= r.payload;
      req_position <= r.position;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      op_req_type directed[$];
      int         phase_pct[4];
      sb = new;
      ms_now = '0;
      idle_pct = 0;
      phase_pct = '{0, 81, 18, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, then fill with entries that never expire
      directed.push_back(mk_op(kemt_pkg::FN_READ_NTH, 8'h00, 8'h00, 0, 0, 0, 0, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h00, 8'h00, 0, 32'hFFFF_FFFF, 0, 32'h0,
                               3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'hFF, 8'hFF, 0, 0, 0, 32'hFFFF_FFFF, 3'd7));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h01, 8'h01, 0, 0, 0, 32'h1111_1111, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h01, 8'h02, 0, 0, 0, 32'h2222_2222, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h02, 8'h01, 0, 0, 0, 32'h3333_3333, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h03, 8'h03, 0, 0, 0, 32'h4444_4444, 3'd0));
      // full of never-expiring entries: refused
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h04, 8'h04, 100, 0, 0, 32'h5555_5555,
                               3'd0));
      // same key overwrites in place
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h01, 8'h01, 0, 0, 0, 32'hA5A5_5A5A, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_READ_NTH, 0, 0, 0, 0, 0, 0, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_READ_NTH, 0, 0, 0, 0, 0, 0, 3'd5));
      directed.push_back(mk_op(kemt_pkg::FN_READ_NTH, 0, 0, 0, 0, 0, 0, 3'd7));
      directed.push_back(mk_op(kemt_pkg::FN_CLR_KEY, 8'h01, 8'h02, 0, 0, 0, 0, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_CLR_KEY, 8'h09, 8'h09, 0, 0, 0, 0, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_CLR_TOPIC, 8'h01, 8'h00, 0, 0, 0, 0, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_CLR_TOPIC, 8'h77, 8'h00, 0, 0, 0, 0, 3'd0));
      // equal finite expiries, then eviction picks the lower slot; expiry wraps
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h05, 8'h05, 50, 1000, 0, 32'h0000_0505,
                               3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h06, 8'h06, 50, 1000, 0, 32'h0000_0606,
                               3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_PUT, 8'h07, 8'h07, 32'h20, 32'hFFFF_FFF0, 0,
                               32'h0000_0707, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 3'd0));
      directed.push_back(mk_op(kemt_pkg::FN_TICK, 0, 0, 0, 0, 32'h0, 0, 3'd0));
      for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++)
         directed.push_back(mk_op(3'(f), 8'($urandom), 8'($urandom), $urandom, $urandom,
                                  $urandom, $urandom, 3'($urandom)));
      foreach (directed[i])
         issue(directed[i]);

      foreach (phase_pct[p]) begin
         idle_pct = phase_pct[p];
         for (int i = 0; i < PHASE_OPS; i++) begin
            sender_gap();
            issue(random_op());
            ms_now = ms_now + $urandom_range(0, 400);
            if (ms_now > 32'd4_000_000)
               ms_now = $urandom_range(0, 1000);
         end
      end
      start <= 1'b0;

      while (sb.awaited_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d table operations, %0d replies compared field by field",
               sb.ops, sb.checked);
      $display("puts stored %0d, puts refused %0d, reads that hit %0d",
               sb.stored, sb.refused, sb.reads_hit);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
